// File: hw/rtl/cstseq_pkg.sv
// Shared constants, types and address helper for the contactor self-test sequencer.
// No dependencies; imported by the core and its checker.
package cstseq_pkg;

  localparam int PHASES           = 3;
  localparam int RELAYS_PER_PHASE = 9;
  localparam int TESTED_RELAYS    = 8;
  localparam int CYCLE_BITS       = 16;

  localparam int NUM_CONTACTORS = PHASES * RELAYS_PER_PHASE;
  localparam int CADDR_W        = $clog2(NUM_CONTACTORS);
  localparam int PHASE_W        = 2;
  localparam int RELAY_W        = 3;
  localparam int QUERY_W        = 5;
  localparam int MUX_W          = 5;
  localparam int COUNT_W        = 4;
  localparam int TIMER_W        = 16;
  localparam int READ_W         = 10;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ONLY_MEASURE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_SETTLE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_READ_SETTLE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_LIMIT   = CFG_IDX_W'(3);

  // Mux line bit that the hardware inverts
  localparam logic [MUX_W-1:0] MUX_INVERT = MUX_W'(16);

  typedef logic [CADDR_W-1:0] caddr_t;

  // Contactor address of (phase, relay)
  function automatic caddr_t addr_of(input logic [PHASE_W-1:0] phase,
                                     input logic [RELAY_W-1:0] relay);
    int a;
    a = int'(phase) * RELAYS_PER_PHASE + int'(relay);
    return a[CADDR_W-1:0];
  endfunction

endpackage

// File: hw/rtl/contactor_self_test_sequencer_core.sv
// Top level of the contactor self-test sequencer: sequencer, fault counters and handshakes.
// Depends on cstseq_pkg and cstseq_ram.
//
// One request is one millisecond tick; the block takes a request in every clock cycle unless
// in_stall is high and shows its result in the cycle after acceptance, held while out_stall is
// high. Throughput is one request per cycle when not stalled, set by the single register stage
// that holds the sequencer state and doubles as the result register; a new request is taken
// while a result is being delivered. Fault counters sit in a small RAM with a check port and a
// query port; per-entry valid bits cleared at reset make them read as zero, so no clearing pass
// is needed after reset. Configuration writes are always ready and take effect on the next tick.
module contactor_self_test_sequencer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_feedback_p1,
  input  logic                                in_feedback_p2,
  input  logic [cstseq_pkg::QUERY_W-1:0]      in_query_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cstseq_pkg::NUM_CONTACTORS-1:0] out_relay_drive,
  output logic [cstseq_pkg::MUX_W-1:0]        out_mux_lines,
  output logic [cstseq_pkg::COUNT_W-1:0]      out_fault_count,
  output logic [cstseq_pkg::RELAY_W-1:0]      out_relay_under_test,
  output logic [cstseq_pkg::CYCLE_BITS-1:0]   out_test_cycles,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cstseq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cstseq_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cstseq_pkg::*;

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_SETTLE_ON  = 3'd1;
  localparam logic [2:0] ST_READ_ON    = 3'd2;
  localparam logic [2:0] ST_SETTLE_OFF = 3'd3;
  localparam logic [2:0] ST_READ_OFF   = 3'd4;

  // Configuration registers
  logic                 only_measure_r;
  logic [TIMER_W-1:0]   switch_settle_r;
  logic [READ_W-1:0]    read_settle_r;
  logic [COUNT_W-1:0]   fault_limit_r;

  // Sequencer state
  logic [2:0]                state_r, state_nxt;
  logic [TIMER_W-1:0]        timer_r, timer_nxt;
  logic [PHASE_W-1:0]        phase_r, phase_nxt;
  logic [RELAY_W-1:0]        relay_r, relay_nxt;
  logic [CYCLE_BITS-1:0]     cyc_r, cyc_nxt;
  logic [NUM_CONTACTORS-1:0] drive_r, drive_nxt;
  logic [MUX_W-1:0]          mux_r, mux_nxt;
  logic [QUERY_W-1:0]        q_r, q_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // Fault counter storage
  logic [NUM_CONTACTORS-1:0] cnt_valid_r;
  logic                      we;
  caddr_t                    waddr, raddr_a, raddr_b, chk_addr, idle_addr;
  logic [COUNT_W-1:0]        wdata, rdata_a, rdata_b, cnt_cur;
  logic                      a_hit_r, b_hit_r;
  logic [COUNT_W-1:0]        a_wd_r, b_wd_r;

  logic                 accept;
  logic [PHASE_W:0]     phase_inc;
  logic [RELAY_W:0]     relay_inc;
  logic [1:0]           fb;
  logic                 is_on, pass;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      only_measure_r  <= 1'b0;
      switch_settle_r <= TIMER_W'(1000);
      read_settle_r   <= READ_W'(100);
      fault_limit_r   <= COUNT_W'(9);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ONLY_MEASURE:  only_measure_r  <= cfg_data[0];
        REG_SWITCH_SETTLE: switch_settle_r <= cfg_data[TIMER_W-1:0];
        REG_READ_SETTLE:   read_settle_r   <= cfg_data[READ_W-1:0];
        REG_FAULT_LIMIT:   fault_limit_r   <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Counter of the contactor under check, bypassing a write of the last cycle
  assign chk_addr = addr_of(phase_r, relay_r);
  always_comb begin
    cnt_cur = '0;
    if (a_hit_r) begin
      cnt_cur = a_wd_r;
    end else if (chk_addr < CADDR_W'(NUM_CONTACTORS) && cnt_valid_r[chk_addr]) begin
      cnt_cur = rdata_a;
    end
  end

  assign fb        = {in_feedback_p2, in_feedback_p1};
  assign is_on     = (chk_addr < CADDR_W'(NUM_CONTACTORS)) ? drive_r[chk_addr] : 1'b0;
  assign pass      = is_on ? (fb == 2'b01) : (fb == 2'b10);
  assign phase_inc = {1'b0, phase_r} + 1'b1;
  assign relay_inc = {1'b0, relay_r} + 1'b1;

  // Advance the sequencer by one tick
  always_comb begin
    state_nxt = state_r;
    timer_nxt = timer_r;
    phase_nxt = phase_r;
    relay_nxt = relay_r;
    cyc_nxt   = cyc_r;
    drive_nxt = drive_r;
    mux_nxt   = mux_r;
    q_nxt     = q_r;
    we        = 1'b0;
    waddr     = chk_addr;
    wdata     = cnt_cur + 1'b1;
    idle_addr = '0;
    if (accept) begin
      q_nxt = in_query_index;
      if (only_measure_r) begin
        state_nxt = ST_IDLE;
        timer_nxt = '0;
        phase_nxt = '0;
        drive_nxt = '0;
      end else begin
        case (state_r)
          ST_IDLE: begin
            for (int ph = 0; ph < PHASES; ph++) begin
              idle_addr = addr_of(PHASE_W'(ph), relay_r);
              if (idle_addr < CADDR_W'(NUM_CONTACTORS)) begin
                drive_nxt[idle_addr] = 1'b1;
              end
            end
            timer_nxt = switch_settle_r;
            state_nxt = ST_SETTLE_ON;
          end
          ST_SETTLE_ON, ST_SETTLE_OFF: begin
            if (timer_r != '0) begin
              timer_nxt = timer_r - 1'b1;
            end else begin
              phase_nxt = '0;
              mux_nxt   = MUX_W'(addr_of('0, relay_r));
              timer_nxt = TIMER_W'(read_settle_r);
              state_nxt = (state_r == ST_SETTLE_ON) ? ST_READ_ON : ST_READ_OFF;
            end
          end
          ST_READ_ON, ST_READ_OFF: begin
            if (timer_r != '0) begin
              timer_nxt = timer_r - 1'b1;
            end else begin
              // Check the contactor and count a failure while below the fault limit
              if (chk_addr < CADDR_W'(NUM_CONTACTORS)) begin
                we = ~pass & (cnt_cur < fault_limit_r);
                if (state_r == ST_READ_ON) begin
                  drive_nxt[chk_addr] = 1'b0;
                end
              end
              if (phase_inc < (PHASE_W+1)'(PHASES)) begin
                phase_nxt = phase_inc[PHASE_W-1:0];
                mux_nxt   = MUX_W'(addr_of(phase_inc[PHASE_W-1:0], relay_r));
                timer_nxt = TIMER_W'(read_settle_r);
              end else begin
                phase_nxt = '0;
                if (state_r == ST_READ_ON) begin
                  timer_nxt = switch_settle_r;
                  state_nxt = ST_SETTLE_OFF;
                end else begin
                  if (relay_inc >= (RELAY_W+1)'(TESTED_RELAYS)) begin
                    relay_nxt = '0;
                    cyc_nxt   = cyc_r + 1'b1;
                  end else begin
                    relay_nxt = relay_inc[RELAY_W-1:0];
                  end
                  state_nxt = ST_IDLE;
                end
              end
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
    end
  end

  // Read addresses track the state of the next cycle
  assign raddr_a = addr_of(phase_nxt, relay_nxt);
  assign raddr_b = q_nxt[CADDR_W-1:0];

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      timer_r     <= '0;
      phase_r     <= '0;
      relay_r     <= '0;
      cyc_r       <= '0;
      drive_r     <= '0;
      mux_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_valid_r <= '0;
      a_hit_r     <= 1'b0;
      b_hit_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      timer_r     <= timer_nxt;
      phase_r     <= phase_nxt;
      relay_r     <= relay_nxt;
      cyc_r       <= cyc_nxt;
      drive_r     <= drive_nxt;
      mux_r       <= mux_nxt;
      out_valid_r <= out_valid_nxt;
      if (we) begin
        cnt_valid_r[waddr] <= 1'b1;
      end
      a_hit_r <= we & (waddr == raddr_a);
      b_hit_r <= we & (waddr == raddr_b);
    end
  end

  // Payload: query index and bypass data
  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    a_wd_r <= wdata;
    b_wd_r <= wdata;
  end

  cstseq_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_CONTACTORS)
  ) u_cnt_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // Drive the result
  always_comb begin
    out_fault_count = '0;
    if (q_r < QUERY_W'(NUM_CONTACTORS)) begin
      if (b_hit_r) begin
        out_fault_count = b_wd_r;
      end else if (cnt_valid_r[q_r[CADDR_W-1:0]]) begin
        out_fault_count = rdata_b;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_relay_drive      = drive_r;
  assign out_mux_lines        = mux_r ^ MUX_INVERT;
  assign out_relay_under_test = relay_r;
  assign out_test_cycles      = cyc_r;

endmodule

// File: hw/rtl/cstseq_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module cstseq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 27
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read both ports old-before-write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: hw/rtl/cstseq_checker.sv
// Port-level checker for the contactor self-test sequencer, bound to the core.
// Depends on cstseq_pkg.
module cstseq_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  in_feedback_p1,
  input logic                                  in_feedback_p2,
  input logic [cstseq_pkg::QUERY_W-1:0]        in_query_index,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic [cstseq_pkg::NUM_CONTACTORS-1:0] out_relay_drive,
  input logic [cstseq_pkg::MUX_W-1:0]          out_mux_lines,
  input logic [cstseq_pkg::COUNT_W-1:0]        out_fault_count,
  input logic [cstseq_pkg::RELAY_W-1:0]        out_relay_under_test,
  input logic [cstseq_pkg::CYCLE_BITS-1:0]     out_test_cycles,
  input logic                                  cfg_valid,
  input logic                                  cfg_ready,
  input logic [cstseq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [cstseq_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cstseq_pkg::*;

  logic [NUM_CONTACTORS-1:0] col_mask;
  caddr_t                    col_addr;

  // Contactors belonging to the relay under test
  always_comb begin
    col_mask = '0;
    col_addr = '0;
    for (int ph = 0; ph < PHASES; ph++) begin
      col_addr = addr_of(PHASE_W'(ph), out_relay_under_test);
      if (col_addr < CADDR_W'(NUM_CONTACTORS)) begin
        col_mask[col_addr] = 1'b1;
      end
    end
  end

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_relay_drive)
      && $stable(out_fault_count) && $stable(out_test_cycles))
    else $error("stalled result changed");

  // Only the relay under test is energized, at most once per phase
  a_drive_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_relay_drive & ~col_mask) == '0)
      && ($countones(out_relay_drive) <= PHASES))
    else $error("relay energized outside the tested column");

  // Mux address points at a real contactor
  a_mux_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_mux_lines ^ MUX_INVERT) < MUX_W'(NUM_CONTACTORS)))
    else $error("mux address out of range");

  // Cycle count only moves when the relay index wraps to zero
  a_cycle_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && (out_test_cycles != $past(out_test_cycles))
      |-> (out_relay_under_test == '0))
    else $error("cycle count advanced without relay wrap");

endmodule

bind contactor_self_test_sequencer_core cstseq_checker u_cstseq_checker (.*);
